// ===== rtl/core/slr_pkg.sv =====
package slr_pkg;

    localparam int NUM_SLOTS  = 8;
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ANGLE_W    = 8;
    localparam int TICK_W     = 16;
    localparam int CAT_W      = 5;
    localparam int REQ_W      = 16;
    localparam int TABLE_W    = 64;
    localparam int CFG_IDX_W  = 2;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 8'd180;
    localparam logic [ANGLE_W-1:0] STEP_FAR   = 8'd20;
    localparam logic [ANGLE_W-1:0] STEP_MID   = 8'd12;
    localparam logic [ANGLE_W-1:0] STEP_NEAR  = 8'd3;
    localparam logic [ANGLE_W-1:0] DIST_FAR   = 8'd90;
    localparam logic [ANGLE_W-1:0] DIST_MID   = 8'd45;
    localparam logic [ANGLE_W-1:0] DIST_NEAR  = 8'd15;
    localparam logic [ANGLE_W-1:0] DEF_STEP_RST = 8'd7;
    localparam logic [TICK_W-1:0]  INTERVAL_RST = 16'd20;
    localparam logic [TICK_W-1:0]  TICK_SAT     = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_CAT   = 2'd1,
        CMD_ANGLE = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOT_ANGLES   = 2'd0,
        REG_STEP_INTERVAL = 2'd1,
        REG_DEFAULT_STEP  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [ANGLE_W-1:0] position;
        logic [ANGLE_W-1:0] goal;
        logic [TICK_W-1:0]  elapsed;
    } t_state;

    typedef struct packed {
        logic [TABLE_W-1:0] slot_angles;
        logic [TICK_W-1:0]  step_interval;
        logic [ANGLE_W-1:0] default_step;
    } t_cfg;

    typedef struct packed {
        logic [ANGLE_W-1:0] position;
        logic [ANGLE_W-1:0] goal;
        logic               stepped;
        logic               settled;
    } t_result;

endpackage

// ===== rtl/core/slr_step.sv =====
module slr_step (
    input  logic [1:0]                       i_cmd,
    input  logic signed [slr_pkg::CAT_W-1:0] i_category,
    input  logic signed [slr_pkg::REQ_W-1:0] i_angle_request,
    input  slr_pkg::t_cfg                    i_cfg,
    input  slr_pkg::t_state                  i_state,
    output slr_pkg::t_state                  o_state,
    output slr_pkg::t_result                 o_result
);

    logic [slr_pkg::SLOT_IDX_W-1:0] slot_idx;
    logic [slr_pkg::ANGLE_W-1:0]    slot_raw;
    logic [slr_pkg::ANGLE_W-1:0]    slot_angle;
    logic [slr_pkg::ANGLE_W-1:0]    req_angle;
    logic [slr_pkg::ANGLE_W-1:0]    distance;
    logic [slr_pkg::ANGLE_W-1:0]    step;
    logic [slr_pkg::ANGLE_W-1:0]    next_pos;
    logic [slr_pkg::TICK_W-1:0]     ticks_inc;
    logic                           move;

    // category clamp and table lookup
    always_comb begin
        if (i_category[slr_pkg::CAT_W-1]) begin
            slot_idx = '0;
        end else if (i_category[slr_pkg::CAT_W-2:0] >
                     (slr_pkg::CAT_W-1)'(slr_pkg::NUM_SLOTS - 1)) begin
            slot_idx = slr_pkg::SLOT_IDX_W'(slr_pkg::NUM_SLOTS - 1);
        end else begin
            slot_idx = i_category[slr_pkg::SLOT_IDX_W-1:0];
        end
        slot_raw   = i_cfg.slot_angles[slot_idx*slr_pkg::ANGLE_W +: slr_pkg::ANGLE_W];
        slot_angle = (slot_raw > slr_pkg::ANGLE_MAX) ? slr_pkg::ANGLE_MAX : slot_raw;
    end

    always_comb begin
        if (i_angle_request[slr_pkg::REQ_W-1]) begin
            req_angle = '0;
        end else if (i_angle_request > $signed({8'd0, slr_pkg::ANGLE_MAX})) begin
            req_angle = slr_pkg::ANGLE_MAX;
        end else begin
            req_angle = i_angle_request[slr_pkg::ANGLE_W-1:0];
        end
    end

    // slew step
    always_comb begin
        ticks_inc = (i_state.elapsed != slr_pkg::TICK_SAT) ?
                    i_state.elapsed + 16'd1 : i_state.elapsed;
        move = (i_state.position != i_state.goal) && (ticks_inc >= i_cfg.step_interval);
        distance = (i_state.goal > i_state.position) ? i_state.goal - i_state.position
                                                     : i_state.position - i_state.goal;
        if (distance > slr_pkg::DIST_FAR) begin
            step = slr_pkg::STEP_FAR;
        end else if (distance > slr_pkg::DIST_MID) begin
            step = slr_pkg::STEP_MID;
        end else if (distance < slr_pkg::DIST_NEAR) begin
            step = slr_pkg::STEP_NEAR;
        end else begin
            step = i_cfg.default_step;
        end
        if (step >= distance) begin
            next_pos = i_state.goal;
        end else if (i_state.position < i_state.goal) begin
            next_pos = i_state.position + step;
        end else begin
            next_pos = i_state.position - step;
        end
    end

    always_comb begin
        o_state          = i_state;
        o_result.stepped = 1'b0;
        case (i_cmd)
            slr_pkg::CMD_CAT: begin
                o_state.goal = slot_angle;
            end
            slr_pkg::CMD_ANGLE: begin
                o_state.goal = req_angle;
            end
            slr_pkg::CMD_TICK: begin
                o_state.elapsed = ticks_inc;
                if (move) begin
                    o_state.elapsed  = '0;
                    o_state.position = next_pos;
                    o_result.stepped = (next_pos != i_state.position);
                end
            end
            default: begin
            end
        endcase
        o_result.position = o_state.position;
        o_result.goal     = o_state.goal;
        o_result.settled  = (o_state.position == o_state.goal);
    end

endmodule

// ===== rtl/core/servo_slew_ramp_positioner.sv =====
// a result is registered in the output register, or in the skid register while the output is stalled
// throughput: one item per cycle while o_in_stall is low, with no dependency between items beyond the state registers
// a two-entry output (result register plus skid register) keeps input stall registered
// reset: synchronous active-low, position and goal return to 0, tick count to 0,
// table to 0, step interval to 20 and default step to 7
module servo_slew_ramp_positioner (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [slr_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [slr_pkg::TABLE_W-1:0]          i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_cmd,
    input  logic signed [slr_pkg::CAT_W-1:0]     i_category,
    input  logic signed [slr_pkg::REQ_W-1:0]     i_angle_request,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [slr_pkg::ANGLE_W-1:0]          o_position,
    output logic [slr_pkg::ANGLE_W-1:0]          o_goal,
    output logic                                 o_stepped,
    output logic                                 o_settled
);

    slr_pkg::t_cfg    r_cfg;
    slr_pkg::t_state  r_state;
    slr_pkg::t_state  n_state;
    slr_pkg::t_result n_res;
    slr_pkg::t_result r_out;
    slr_pkg::t_result r_skd;
    logic             r_out_valid;
    logic             r_skd_valid;
    logic             in_xfer;
    logic             out_xfer;

    assign o_in_stall = r_skd_valid;
    assign in_xfer    = i_in_valid && !r_skd_valid;
    assign out_xfer   = r_out_valid && !i_out_stall;

    slr_step u_step (
        .i_cmd           (i_cmd),
        .i_category      (i_category),
        .i_angle_request (i_angle_request),
        .i_cfg           (r_cfg),
        .i_state         (r_state),
        .o_state         (n_state),
        .o_result        (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slot_angles   <= '0;
            r_cfg.step_interval <= slr_pkg::INTERVAL_RST;
            r_cfg.default_step  <= slr_pkg::DEF_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                slr_pkg::REG_SLOT_ANGLES: begin
                    r_cfg.slot_angles <= i_cfg_data;
                end
                slr_pkg::REG_STEP_INTERVAL: begin
                    r_cfg.step_interval <= i_cfg_data[slr_pkg::TICK_W-1:0];
                end
                slr_pkg::REG_DEFAULT_STEP: begin
                    r_cfg.default_step <= i_cfg_data[slr_pkg::ANGLE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            if (out_xfer) begin
                r_skd_valid <= 1'b0;
            end
        end else if (in_xfer) begin
            if (!r_out_valid || out_xfer) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skd_valid <= 1'b1;
            end
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (out_xfer) begin
                r_out <= r_skd;
            end
        end else if (in_xfer) begin
            if (!r_out_valid || out_xfer) begin
                r_out <= n_res;
            end else begin
                r_skd <= n_res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = r_out.position;
    assign o_goal      = r_out.goal;
    assign o_stepped   = r_out.stepped;
    assign o_settled   = r_out.settled;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid entry held without an output entry");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.position <= slr_pkg::ANGLE_MAX) && (r_state.goal <= slr_pkg::ANGLE_MAX))
        else $error("position or goal beyond angle limit");

    a_step_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && n_res.stepped) |=> (r_state.elapsed == '0))
        else $error("tick count not cleared after a step");

    a_set_holds_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_cmd != slr_pkg::CMD_TICK)) |=>
        (r_state.position == $past(r_state.position)))
        else $error("set command moved the position");

endmodule

// ===== verif/servo_slew_ramp_positioner_checker.sv =====
module servo_slew_ramp_positioner_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [slr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [slr_pkg::TABLE_W-1:0]      i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [1:0]                       i_cmd,
    input  logic signed [slr_pkg::CAT_W-1:0] i_category,
    input  logic signed [slr_pkg::REQ_W-1:0] i_angle_request,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [slr_pkg::ANGLE_W-1:0]      i_position,
    input  logic [slr_pkg::ANGLE_W-1:0]      i_goal,
    input  logic                             i_stepped,
    input  logic                             i_settled,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_result_count,
    output int                               o_step_count
);
    timeunit 1ns;
    timeprecision 1ps;

    slr_pkg::t_state  servo;
    slr_pkg::t_cfg    settings;
    slr_pkg::t_result expected_poses[$];

    function automatic slr_pkg::t_result slew_toward_goal(
        input logic [1:0]                       cmd,
        input logic signed [slr_pkg::CAT_W-1:0] cat,
        input logic signed [slr_pkg::REQ_W-1:0] req);
        slr_pkg::t_result            res;
        int                          slot;
        logic [slr_pkg::ANGLE_W-1:0] slot_raw;
        logic [slr_pkg::ANGLE_W-1:0] distance;
        logic [slr_pkg::ANGLE_W-1:0] stride;
        logic [slr_pkg::ANGLE_W-1:0] next_pos;
        res.stepped = 1'b0;
        case (cmd)
            slr_pkg::CMD_CAT: begin
                slot = (cat < 0) ? 0 :
                       (cat > slr_pkg::NUM_SLOTS - 1) ? slr_pkg::NUM_SLOTS - 1 : int'(cat);
                slot_raw = settings.slot_angles[slot*slr_pkg::ANGLE_W +: slr_pkg::ANGLE_W];
                servo.goal = (slot_raw > slr_pkg::ANGLE_MAX) ? slr_pkg::ANGLE_MAX : slot_raw;
            end
            slr_pkg::CMD_ANGLE: begin
                servo.goal = (req < 0) ? 8'd0 :
                             (req > 180) ? slr_pkg::ANGLE_MAX : req[slr_pkg::ANGLE_W-1:0];
            end
            slr_pkg::CMD_TICK: begin
                if (servo.elapsed != slr_pkg::TICK_SAT)
                    servo.elapsed = servo.elapsed + 1'b1;
                if (servo.position != servo.goal &&
                    servo.elapsed >= settings.step_interval) begin
                    servo.elapsed = '0;
                    distance = (servo.goal > servo.position) ? servo.goal - servo.position
                                                             : servo.position - servo.goal;
                    if (distance > slr_pkg::DIST_FAR)
                        stride = slr_pkg::STEP_FAR;
                    else if (distance > slr_pkg::DIST_MID)
                        stride = slr_pkg::STEP_MID;
                    else if (distance < slr_pkg::DIST_NEAR)
                        stride = slr_pkg::STEP_NEAR;
                    else
                        stride = settings.default_step;
                    if (stride >= distance)
                        next_pos = servo.goal;
                    else if (servo.position < servo.goal)
                        next_pos = servo.position + stride;
                    else
                        next_pos = servo.position - stride;
                    res.stepped = (next_pos != servo.position);
                    servo.position = next_pos;
                end
            end
            default: ;
        endcase
        res.position = servo.position;
        res.goal     = servo.goal;
        res.settled  = (servo.position == servo.goal);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        slr_pkg::t_result want;
        if (!i_rst_n) begin
            servo                  = '0;
            settings.slot_angles   = '0;
            settings.step_interval = slr_pkg::INTERVAL_RST;
            settings.default_step  = slr_pkg::DEF_STEP_RST;
            expected_poses.delete();
            o_fail_count   = 0;
            o_pending      = 0;
            o_result_count = 0;
            o_step_count   = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    slr_pkg::REG_SLOT_ANGLES:
                        settings.slot_angles   = i_cfg_data;
                    slr_pkg::REG_STEP_INTERVAL:
                        settings.step_interval = i_cfg_data[slr_pkg::TICK_W-1:0];
                    slr_pkg::REG_DEFAULT_STEP:
                        settings.default_step  = i_cfg_data[slr_pkg::ANGLE_W-1:0];
                    default: ;
                endcase
            end
            // result transfer belongs to a command accepted on an earlier edge
            if (i_out_valid && !i_out_stall) begin
                if (expected_poses.size() == 0) begin
                    $error("result with no command outstanding: position %0d goal %0d",
                           i_position, i_goal);
                    o_fail_count++;
                end else begin
                    want = expected_poses.pop_front();
                    o_result_count++;
                    if (want.stepped)
                        o_step_count++;
                    if (i_position !== want.position) begin
                        $error("position: expected %0d, got %0d", want.position, i_position);
                        o_fail_count++;
                    end
                    if (i_goal !== want.goal) begin
                        $error("goal: expected %0d, got %0d", want.goal, i_goal);
                        o_fail_count++;
                    end
                    if (i_stepped !== want.stepped) begin
                        $error("stepped: expected %0d, got %0d", want.stepped, i_stepped);
                        o_fail_count++;
                    end
                    if (i_settled !== want.settled) begin
                        $error("settled: expected %0d, got %0d", want.settled, i_settled);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_poses.push_back(slew_toward_goal(i_cmd, i_category, i_angle_request));
            o_pending = expected_poses.size();
        end
    end

endmodule

// ===== verif/servo_slew_ramp_positioner_test.sv =====
module servo_slew_ramp_positioner_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 175;
    localparam int HOLD_TICKS   = 20;

    logic                             clk             = 1'b0;
    logic                             rst_n           = 1'b0;
    logic                             cfg_we          = 1'b0;
    logic [slr_pkg::CFG_IDX_W-1:0]    cfg_idx         = '0;
    logic [slr_pkg::TABLE_W-1:0]      cfg_data        = '0;
    logic                             in_valid        = 1'b0;
    logic                             in_stall;
    logic [1:0]                       cmd             = slr_pkg::CMD_TICK;
    logic signed [slr_pkg::CAT_W-1:0] category        = '0;
    logic signed [slr_pkg::REQ_W-1:0] angle_request   = '0;
    logic                             out_valid;
    logic                             out_stall       = 1'b0;
    logic [slr_pkg::ANGLE_W-1:0]      position;
    logic [slr_pkg::ANGLE_W-1:0]      goal;
    logic                             stepped;
    logic                             settled;

    int fail_count;
    int pending;
    int result_count;
    int step_count;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int commands_sent      = 0;
    int config_writes      = 0;

    int          interval_plan[PHASES] = '{0, 1, 4, 2, 25, 3, 0, 65535};
    int          step_plan[PHASES]     = '{1, 180, 0, 255, 7, 13, 30, 9};
    int          sender_plan[4]        = '{0, 60, 0, 31};
    int          stall_plan[4]         = '{0, 0, 60, 31};

    servo_slew_ramp_positioner uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_cmd           (cmd),
        .i_category      (category),
        .i_angle_request (angle_request),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_position      (position),
        .o_goal          (goal),
        .o_stepped       (stepped),
        .o_settled       (settled)
    );

    servo_slew_ramp_positioner_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_cmd           (cmd),
        .i_category      (category),
        .i_angle_request (angle_request),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_position      (position),
        .i_goal          (goal),
        .i_stepped       (stepped),
        .i_settled       (settled),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_result_count  (result_count),
        .o_step_count    (step_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    task automatic send_item(input logic [1:0] op,
                             input logic signed [slr_pkg::CAT_W-1:0] cat,
                             input logic signed [slr_pkg::REQ_W-1:0] req);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        cmd           <= op;
        category      <= cat;
        angle_request <= req;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        commands_sent++;
    endtask

    // hold off the sender until every outstanding result has been seen
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input slr_pkg::t_reg_idx idx,
                             input logic [slr_pkg::TABLE_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        config_writes++;
    endtask

    task automatic random_command();
        int pick;
        pick = $urandom_range(99);
        if (pick < 58)
            send_item(slr_pkg::CMD_TICK, slr_pkg::CAT_W'($urandom),
                      slr_pkg::REQ_W'($urandom));
        else if (pick < 72)
            send_item(slr_pkg::CMD_CAT, slr_pkg::CAT_W'($urandom),
                      slr_pkg::REQ_W'($urandom));
        else if (pick < 80)
            send_item(slr_pkg::CMD_ANGLE, slr_pkg::CAT_W'($urandom),
                      slr_pkg::REQ_W'($urandom));
        else if (pick < 92)
            send_item(slr_pkg::CMD_ANGLE, slr_pkg::CAT_W'($urandom),
                      slr_pkg::REQ_W'($urandom_range(210) - 10));
        else
            send_item(CMD_SPARE, slr_pkg::CAT_W'($urandom), slr_pkg::REQ_W'($urandom));
    endtask

    initial begin
        #4_000_000;
        $display("** servo_slew_ramp_positioner: FAILED **");
        $finish;
    end

    initial begin
        logic [slr_pkg::TABLE_W-1:0] slots;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: spare code and the extremes of the angle field
        send_item(CMD_SPARE, -5'sd1, 16'hFFFF);
        send_item(slr_pkg::CMD_TICK, 5'sd15, 16'h7FFF);
        send_item(slr_pkg::CMD_ANGLE, 5'sd0, -16'sd32768);
        send_item(slr_pkg::CMD_ANGLE, -5'sd8, 16'sd32767);
        send_item(slr_pkg::CMD_TICK, 5'sd0, 16'h0000);

        // slots 0..7: 0 10 30 45 180 255 181 90
        drain();
        write_reg(slr_pkg::REG_SLOT_ANGLES,
                  {8'd90, 8'd181, 8'd255, 8'd180, 8'd45, 8'd30, 8'd10, 8'd0});
        write_reg(slr_pkg::REG_STEP_INTERVAL, 64'd0);
        write_reg(slr_pkg::REG_DEFAULT_STEP, 64'd0);

        send_item(slr_pkg::CMD_CAT, 5'sd5, 16'h1234);
        repeat (5) send_item(slr_pkg::CMD_TICK, slr_pkg::CAT_W'($urandom),
                             slr_pkg::REQ_W'($urandom));
        send_item(slr_pkg::CMD_ANGLE, 5'sd0, 16'sd130);
        send_item(slr_pkg::CMD_TICK, 5'sd0, 16'sd0);
        send_item(slr_pkg::CMD_ANGLE, 5'sd0, 16'sd107);
        send_item(slr_pkg::CMD_TICK, 5'sd0, 16'sd0);
        send_item(slr_pkg::CMD_CAT, 5'sd15, 16'sd0);
        send_item(slr_pkg::CMD_TICK, 5'sd0, 16'sd0);
        send_item(slr_pkg::CMD_CAT, -5'sd8, 16'sd0);
        send_item(slr_pkg::CMD_TICK, 5'sd0, 16'sd0);
        send_item(slr_pkg::CMD_TICK, 5'sd0, 16'sd0);
        send_item(slr_pkg::CMD_ANGLE, 5'sd0, 16'sd66);
        send_item(slr_pkg::CMD_TICK, 5'sd0, 16'sd0);
        send_item(slr_pkg::CMD_CAT, 5'sd6, 16'sd0);
        send_item(slr_pkg::CMD_CAT, 5'sd4, 16'sd0);
        send_item(CMD_SPARE, 5'sd0, 16'sd0);

        // longest interval: ticks count up without a step, then a new goal
        drain();
        write_reg(slr_pkg::REG_STEP_INTERVAL, 64'd65535);
        write_reg(slr_pkg::REG_DEFAULT_STEP, 64'd7);
        send_item(slr_pkg::CMD_ANGLE, 5'sd0, 16'sd66);
        repeat (HOLD_TICKS) send_item(slr_pkg::CMD_TICK, slr_pkg::CAT_W'($urandom),
                                      slr_pkg::REQ_W'($urandom));
        send_item(slr_pkg::CMD_ANGLE, 5'sd0, 16'sd0);
        send_item(slr_pkg::CMD_TICK, 5'sd0, 16'sd0);
        send_item(slr_pkg::CMD_TICK, 5'sd0, 16'sd0);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 0)
                slots = '1;
            else if (phase == 1)
                slots = '0;
            else
                slots = {$urandom, $urandom};
            drain();
            write_reg(slr_pkg::REG_SLOT_ANGLES, slots);
            write_reg(slr_pkg::REG_STEP_INTERVAL, slr_pkg::TABLE_W'(interval_plan[phase]));
            write_reg(slr_pkg::REG_DEFAULT_STEP, slr_pkg::TABLE_W'(step_plan[phase]));
            sender_idle_pct    = sender_plan[phase % 4];
            receiver_stall_pct = stall_plan[phase % 4];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 3 && n == PHASE_ITEMS / 2)
                    drain();
                random_command();
            end
        end

        sender_idle_pct = 0;
        drain();
        repeat (10) @(posedge clk);

        $display("covered %0d commands across %0d register settings (%0d writes)",
                 commands_sent, PHASES + 3, config_writes);
        $display("checked %0d results, %0d of them angle steps", result_count, step_count);
        if (pending != 0)
            $error("%0d results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("** servo_slew_ramp_positioner: PASSED **");
        end else begin
            $display("** servo_slew_ramp_positioner: FAILED **");
        end
        $finish;
    end

endmodule
